// ===== design/apgs_pkg.sv =====
// ----------------------------------------------------------------------------
// apgs_pkg
// Shared types and constants of the aligned pair affine gap scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package apgs_pkg;

  localparam int ALPHABET_BITS_DEF = 5;
  localparam int COUNT_BITS_DEF    = 20;

  localparam int CHAR_W    = 8;
  localparam int SUBST_W   = 8;
  localparam int PENALTY_W = 10;
  localparam int SCORE_W   = 32;
  localparam int OUT_CNT_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  localparam logic [CHAR_W-1:0] GAP_CHAR = 8'h2D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MODEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND = 2'd2;

  localparam logic CMD_COLUMN = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    MARK_BLANK = 2'd0,
    MARK_BAR   = 2'd1,
    MARK_COLON = 2'd2
  } marker_t;

  typedef struct packed {
    logic                      cmd;
    logic [CHAR_W-1:0]         char_first;
    logic [CHAR_W-1:0]         char_second;
    logic signed [SUBST_W-1:0] table_value;
    logic                      is_last;
  } in_item_t;

  typedef struct packed {
    marker_t                   marker;
    logic                      final_res;
    logic signed [SCORE_W-1:0] total_score;
    logic [OUT_CNT_W-1:0]      identities;
    logic [OUT_CNT_W-1:0]      ungapped_len_first;
    logic [OUT_CNT_W-1:0]      ungapped_len_second;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/apgs_table.sv =====
// ----------------------------------------------------------------------------
// apgs_table
// Substitution score memory: one write port, one read port with registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module apgs_table
  import apgs_pkg::*;
#(
  parameter int ALPHABET_BITS = ALPHABET_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [2*ALPHABET_BITS-1:0]      wr_addr,
  input  wire logic signed [SUBST_W-1:0]       wr_data,
  input  wire logic                            rd_en,
  input  wire logic [2*ALPHABET_BITS-1:0]      rd_addr,
  output logic signed [SUBST_W-1:0]            rd_data
);

  localparam int DEPTH = 1 << (2 * ALPHABET_BITS);

  logic signed [SUBST_W-1:0] mem [DEPTH];
  logic signed [SUBST_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/aligned_pair_affine_gap_scorer.sv =====
// ----------------------------------------------------------------------------
// aligned_pair_affine_gap_scorer
// Scores a streamed pairwise alignment column by column with a loaded
// substitution table and affine gap penalties.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carries one beat per column or table load.
//   A load beat (cmd = 1) writes one table entry and gives no result.
//   A column beat gives exactly one result beat on out_valid/out_stall/out_data
//   with its marker; the beat of the column marked is_last also carries the
//   totals, after which the accumulators restart for the next pair.
//   cfg_we/cfg_index/cfg_wdata write the three setup registers; the user must do
//   so only while the block holds no unfinished beat; the block does not enforce it.
// Timing:
//   The accept edge does the registered table read; once the output register is
//   free, a later edge accumulates into it and out_valid rises.
//   one beat per cycle sustained while out_stall is low; the accumulators close
//   their loop combinationally, so back to back columns of one pair never wait.
// Reset: all accumulators and valids clear, use_model = 1, penalties = 0.
//   table contents are undefined until loaded.
// Stall: the output register holds while out_stall is high; one further
//   column waits in the compute stage, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_pair_affine_gap_scorer
  import apgs_pkg::*;
#(
  parameter int ALPHABET_BITS = ALPHABET_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int ADDR_W = 2 * ALPHABET_BITS;

  // configuration
  logic                 use_model_r;
  logic [PENALTY_W-1:0] gap_open_r;
  logic [PENALTY_W-1:0] gap_extend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_model_r  <= 1'b1;
      gap_open_r   <= '0;
      gap_extend_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_MODEL:  use_model_r  <= cfg_wdata[0];
        CFG_GAP_OPEN:   gap_open_r   <= cfg_wdata[PENALTY_W-1:0];
        CFG_GAP_EXTEND: gap_extend_r <= cfg_wdata[PENALTY_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic     s1_valid_r;
  in_item_t s1_r;
  logic     out_valid_r;
  out_item_t out_r;
  logic     out_free;
  logic     s1_done;
  logic     in_accept;
  logic     col_accept;
  logic     load_accept;

  assign out_free    = !out_valid_r || !out_stall;
  assign s1_done     = s1_valid_r && out_free;
  assign in_stall    = s1_valid_r && !out_free;
  assign in_accept   = in_valid && !in_stall;
  assign col_accept  = in_accept && (in_data.cmd == CMD_COLUMN);
  assign load_accept = in_accept && (in_data.cmd == CMD_LOAD);

  logic [ADDR_W-1:0]         tbl_addr;
  logic signed [SUBST_W-1:0] tbl_rdata;

  assign tbl_addr = {in_data.char_first[ALPHABET_BITS-1:0],
                     in_data.char_second[ALPHABET_BITS-1:0]};

  apgs_table #(
    .ALPHABET_BITS(ALPHABET_BITS)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_accept),
    .wr_addr (tbl_addr),
    .wr_data (in_data.table_value),
    .rd_en   (!in_stall),
    .rd_addr (tbl_addr),
    .rd_data (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (col_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (col_accept) begin
      s1_r <= in_data;
    end
  end

  // accumulators
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic                      in_gap_r;
  logic [COUNT_BITS-1:0]     match_r, match_nxt;
  logic [COUNT_BITS-1:0]     len1_r, len1_nxt;
  logic [COUNT_BITS-1:0]     len2_r, len2_nxt;

  logic                      gap_a, gap_b, gap, equal;
  logic [PENALTY_W-1:0]      pen;
  logic signed [SCORE_W:0]   delta;
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] sum_sat;
  logic [63:0]               match_ext, len1_ext, len2_ext;
  out_item_t                 res;

  always_comb begin
    gap_a = (s1_r.char_first == GAP_CHAR);
    gap_b = (s1_r.char_second == GAP_CHAR);
    gap   = gap_a || gap_b;
    equal = (s1_r.char_first == s1_r.char_second);

    // saturating counters: the increment drops out once all ones
    len1_nxt  = gap_a ? len1_r
                      : len1_r + {{(COUNT_BITS-1){1'b0}}, ~&len1_r};
    len2_nxt  = gap_b ? len2_r
                      : len2_r + {{(COUNT_BITS-1){1'b0}}, ~&len2_r};
    match_nxt = (!gap && equal) ? match_r + {{(COUNT_BITS-1){1'b0}}, ~&match_r}
                                : match_r;

    pen   = in_gap_r ? gap_extend_r : gap_open_r;
    delta = gap ? -$signed({{(SCORE_W+1-PENALTY_W){1'b0}}, pen})
                : {{(SCORE_W+1-SUBST_W){tbl_rdata[SUBST_W-1]}}, tbl_rdata};
    sum   = {score_r[SCORE_W-1], score_r} + delta;
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      sum_sat = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                             : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      sum_sat = sum[SCORE_W-1:0];
    end
    score_nxt = use_model_r ? sum_sat : score_r;

    res.marker = MARK_BLANK;
    if (use_model_r) begin
      if (!gap) begin
        if (equal) begin
          res.marker = MARK_BAR;
        end else if (!tbl_rdata[SUBST_W-1] && (tbl_rdata != '0)) begin
          res.marker = MARK_COLON;
        end
      end
    end else if (!gap && equal) begin
      res.marker = MARK_BAR;
    end

    match_ext = 64'(match_nxt);
    len1_ext  = 64'(len1_nxt);
    len2_ext  = 64'(len2_nxt);

    res.final_res           = 1'b0;
    res.total_score         = '0;
    res.identities          = '0;
    res.ungapped_len_first  = '0;
    res.ungapped_len_second = '0;
    if (s1_r.is_last) begin
      res.final_res           = 1'b1;
      res.total_score         = use_model_r ? score_nxt
                                            : {1'b0, match_ext[SCORE_W-2:0]};
      res.identities          = match_ext[OUT_CNT_W-1:0];
      res.ungapped_len_first  = len1_ext[OUT_CNT_W-1:0];
      res.ungapped_len_second = len2_ext[OUT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r  <= '0;
      in_gap_r <= 1'b0;
      match_r  <= '0;
      len1_r   <= '0;
      len2_r   <= '0;
    end else if (s1_done) begin
      if (s1_r.is_last) begin
        score_r  <= '0;
        in_gap_r <= 1'b0;
        match_r  <= '0;
        len1_r   <= '0;
        len2_r   <= '0;
      end else begin
        score_r  <= score_nxt;
        in_gap_r <= gap;
        match_r  <= match_nxt;
        len1_r   <= len1_nxt;
        len2_r   <= len2_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_done && s1_r.is_last) |=>
      (score_r == '0 && match_r == '0 && len1_r == '0 && len2_r == '0 && !in_gap_r))
    else $error("accumulators not cleared after last column");

  a_zero_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.final_res) |->
      (out_r.total_score == '0 && out_r.identities == '0 &&
       out_r.ungapped_len_first == '0 && out_r.ungapped_len_second == '0))
    else $error("totals present on a non-final result");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_r)))
    else $error("compute stage lost a column under stall");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(s1_valid_r))
    else $error("result produced without a column in flight");

endmodule

`default_nettype wire

// ===== tb/sv/apgs_score_checker.sv =====
// ----------------------------------------------------------------------------
// apgs_score_checker
// Watches the column and result channels of the aligned pair scorer, keeps
// its own copy of the substitution table, accumulators and setup registers,
// and compares every result beat against the predicted column result.
// ----------------------------------------------------------------------------
module apgs_score_checker
  import apgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   errors,
  output int                   waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AB = ALPHABET_BITS_DEF;
  localparam bit [31:0] CNT_CEIL = (32'd1 << COUNT_BITS_DEF) - 32'd1;
  localparam longint SCORE_HI = 64'sd2147483647;
  localparam longint SCORE_LO = -64'sd2147483648;

  logic signed [SUBST_W-1:0] subst_mem [0:(1 << (2 * AB)) - 1];
  logic signed [SCORE_W-1:0] score_acc;
  bit                        in_gap_run;
  bit [31:0]                 ident_cnt;
  bit [31:0]                 len_a_cnt;
  bit [31:0]                 len_b_cnt;
  bit                        model_on;
  bit [PENALTY_W-1:0]        open_pen;
  bit [PENALTY_W-1:0]        ext_pen;
  out_item_t                 expected_cols [$];
  int                        beat_no;

  function automatic bit [31:0] sat_inc(bit [31:0] c);
    return (c >= CNT_CEIL) ? CNT_CEIL : c + 32'd1;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch, result beat %0d: %s", $time, beat_no, msg);
    errors++;
  endtask

  task automatic score_column(in_item_t it);
    bit                        gap_a;
    bit                        gap_b;
    bit                        gap;
    bit                        same;
    logic [2*AB-1:0]           idx;
    logic signed [SUBST_W-1:0] s;
    longint                    sum;
    out_item_t                 r;
    gap_a = (it.char_first == GAP_CHAR);
    gap_b = (it.char_second == GAP_CHAR);
    gap   = gap_a || gap_b;
    same  = (it.char_first == it.char_second);
    idx   = {it.char_first[AB-1:0], it.char_second[AB-1:0]};
    r = '0;
    r.marker = MARK_BLANK;
    if (!gap_a) len_a_cnt = sat_inc(len_a_cnt);
    if (!gap_b) len_b_cnt = sat_inc(len_b_cnt);
    if (!gap && same) ident_cnt = sat_inc(ident_cnt);
    if (model_on) begin
      if (gap) begin
        sum = longint'(score_acc) - longint'(in_gap_run ? ext_pen : open_pen);
      end else begin
        s = subst_mem[idx];
        sum = longint'(score_acc) + longint'(s);
        if (same) r.marker = MARK_BAR;
        else if (s > 0) r.marker = MARK_COLON;
      end
      if (sum > SCORE_HI) score_acc = SCORE_HI[31:0];
      else if (sum < SCORE_LO) score_acc = SCORE_LO[31:0];
      else score_acc = sum[31:0];
    end else if (!gap && same) begin
      r.marker = MARK_BAR;
    end
    in_gap_run = gap;
    if (it.is_last) begin
      r.final_res           = 1'b1;
      r.total_score         = model_on ? score_acc : ident_cnt;
      r.identities          = ident_cnt[OUT_CNT_W-1:0];
      r.ungapped_len_first  = len_a_cnt[OUT_CNT_W-1:0];
      r.ungapped_len_second = len_b_cnt[OUT_CNT_W-1:0];
      // pair closed, accumulators restart
      score_acc  = '0;
      in_gap_run = 1'b0;
      ident_cnt  = '0;
      len_a_cnt  = '0;
      len_b_cnt  = '0;
    end
    expected_cols.push_back(r);
  endtask

  task automatic check_beat(out_item_t got);
    out_item_t want;
    beat_no++;
    if (expected_cols.size() == 0) begin
      flag_mismatch("result beat with no column waiting");
      return;
    end
    want = expected_cols.pop_front();
    if (got.marker !== want.marker)
      flag_mismatch($sformatf("marker %0d, want %0d", got.marker, want.marker));
    if (got.final_res !== want.final_res)
      flag_mismatch($sformatf("final_res %0b, want %0b", got.final_res, want.final_res));
    if (got.total_score !== want.total_score)
      flag_mismatch($sformatf("total_score %0d, want %0d", got.total_score,
                              want.total_score));
    if (got.identities !== want.identities)
      flag_mismatch($sformatf("identities %0d, want %0d", got.identities,
                              want.identities));
    if (got.ungapped_len_first !== want.ungapped_len_first)
      flag_mismatch($sformatf("ungapped_len_first %0d, want %0d",
                              got.ungapped_len_first, want.ungapped_len_first));
    if (got.ungapped_len_second !== want.ungapped_len_second)
      flag_mismatch($sformatf("ungapped_len_second %0d, want %0d",
                              got.ungapped_len_second, want.ungapped_len_second));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_cols.delete();
      score_acc  = '0;
      in_gap_run = 1'b0;
      ident_cnt  = '0;
      len_a_cnt  = '0;
      len_b_cnt  = '0;
      model_on   = 1'b1;
      open_pen   = '0;
      ext_pen    = '0;
      beat_no    = 0;
    end else begin
      // compare before predicting: a beat leaving now never belongs to one entering now
      if (out_valid && !out_stall) check_beat(out_data);
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_LOAD)
          subst_mem[{in_data.char_first[AB-1:0], in_data.char_second[AB-1:0]}] =
            in_data.table_value;
        else
          score_column(in_data);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_USE_MODEL:  model_on = cfg_wdata[0];
          CFG_GAP_OPEN:   open_pen = cfg_wdata[PENALTY_W-1:0];
          CFG_GAP_EXTEND: ext_pen  = cfg_wdata[PENALTY_W-1:0];
          default: ;
        endcase
      end
    end
    waiting = expected_cols.size();
  end

endmodule

// ===== tb/sv/aligned_pair_affine_gap_scorer_tb.sv =====
// ----------------------------------------------------------------------------
// aligned_pair_affine_gap_scorer_tb
// Streams table loads and alignment columns into the scorer under several
// penalty and model settings, with random idling on both channels and one
// long output hold; the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module aligned_pair_affine_gap_scorer_tb;
  import apgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AB          = ALPHABET_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 376;
  localparam logic [CHAR_W-1:0] ALPHA [8] =
    '{8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_USE_MODEL;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int  errors;
  int  waiting;
  bit  table_set [0:(1 << (2 * AB)) - 1];
  int  phase = 0;
  bit  quiet = 1'b0;
  bit  held  = 1'b0;
  bit  prev_gap = 1'b0;
  int  n_beats, n_cols, n_loads, n_pairs, n_settings;
  int  cycle_cnt;

  aligned_pair_affine_gap_scorer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  apgs_score_checker score_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .waiting   (waiting)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, waiting);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stall bursts, one long hold, none at the end
  initial begin
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (phase == 2 && !held) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task automatic send(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    n_beats++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic load_entry(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b,
                            logic [SUBST_W-1:0] value, bit last);
    in_item_t it;
    it.cmd         = CMD_LOAD;
    it.char_first  = a;
    it.char_second = b;
    it.table_value = value;
    it.is_last     = last;
    table_set[{a[AB-1:0], b[AB-1:0]}] = 1'b1;
    n_loads++;
    send(it);
  endtask

  task automatic column(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b, bit last);
    in_item_t it;
    // never let a scored column read a table entry that was not loaded
    if (a != GAP_CHAR && b != GAP_CHAR && !table_set[{a[AB-1:0], b[AB-1:0]}])
      load_entry(a, b, SUBST_W'($urandom), 1'($urandom_range(0, 1)));
    it.cmd         = CMD_COLUMN;
    it.char_first  = a;
    it.char_second = b;
    it.table_value = SUBST_W'($urandom);
    it.is_last     = last;
    prev_gap = (a == GAP_CHAR) || (b == GAP_CHAR);
    n_cols++;
    if (last) n_pairs++;
    send(it);
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return GAP_CHAR;
    if (r < 82) return ALPHA[3'($urandom_range(0, 7))];
    return CHAR_W'($urandom);
  endfunction

  task automatic random_pairs(int n_items);
    int                stop;
    int                len;
    logic [CHAR_W-1:0] a;
    logic [CHAR_W-1:0] b;
    stop = n_beats + n_items;
    while (n_beats < stop) begin
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          load_entry(CHAR_W'($urandom), CHAR_W'($urandom), SUBST_W'($urandom),
                     1'($urandom_range(0, 1)));
        a = pick_char();
        b = ($urandom_range(0, 2) == 0) ? a : pick_char();
        // stretch gap runs so extension penalties show up often
        if (prev_gap && $urandom_range(0, 1) == 1) begin
          if ($urandom_range(0, 1) == 1) a = GAP_CHAR;
          else b = GAP_CHAR;
        end
        column(a, b, i == len - 1);
      end
    end
  endtask

  task automatic set_regs(bit model, logic [PENALTY_W-1:0] open_p,
                          logic [PENALTY_W-1:0] ext_p);
    logic [CFG_DAT_W-2:0] pad;
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    @(posedge clk);
    repeat (4) @(posedge clk);
    pad = (CFG_DAT_W-1)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_USE_MODEL;
    cfg_wdata <= {pad, model};
    @(posedge clk);
    cfg_index <= CFG_GAP_OPEN;
    cfg_wdata <= open_p;
    @(posedge clk);
    cfg_index <= CFG_GAP_EXTEND;
    cfg_wdata <= ext_p;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(1'b1, 10'd7, 10'd2);
    phase = 1;
    load_entry(8'h41, 8'h41, 8'sd127, 1'b1);
    load_entry(8'h43, 8'h47, -8'sd128, 1'b0);
    load_entry(8'h00, 8'h00, 8'sd0, 1'b0);
    load_entry(8'hFF, 8'h00, 8'sd1, 1'b0);
    load_entry(8'hFF, 8'hFF, -8'sd1, 1'b0);
    column(8'h41, 8'h41, 1'b0);
    // same table entry as the identity above, bytes differ
    column(8'h61, 8'h41, 1'b0);
    column(8'h43, 8'h47, 1'b0);
    column(8'h00, 8'h00, 1'b0);
    column(8'hFF, 8'h00, 1'b0);
    column(8'hFF, 8'hFF, 1'b0);
    column(8'h41, GAP_CHAR, 1'b0);
    column(GAP_CHAR, 8'h41, 1'b0);
    column(GAP_CHAR, GAP_CHAR, 1'b0);
    column(8'h43, 8'h47, 1'b0);
    column(GAP_CHAR, 8'h43, 1'b1);
    column(8'h41, 8'h41, 1'b1);
    column(GAP_CHAR, GAP_CHAR, 1'b1);

    set_regs(1'b0, 10'd0, 10'd0);
    phase = 2;
    random_pairs(PHASE_ITEMS);
    set_regs(1'b1, 10'd1023, 10'd1023);
    phase = 3;
    random_pairs(PHASE_ITEMS);
    set_regs(1'b1, 10'd0, 10'd1023);
    phase = 4;
    random_pairs(PHASE_ITEMS);
    set_regs(1'b1, PENALTY_W'($urandom_range(0, 1023)), PENALTY_W'($urandom_range(0, 40)));
    phase = 5;
    random_pairs(PHASE_ITEMS);
    quiet = 1'b1;
    set_regs(1'b1, PENALTY_W'($urandom_range(0, 63)), PENALTY_W'($urandom_range(0, 15)));
    phase = 6;
    random_pairs(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d input beats: %0d columns in %0d closed pairs, %0d table loads",
             n_beats, n_cols, n_pairs, n_loads);
    $display("%0d register settings incl. model off and penalties at 0 and 1023, %0d errors",
             n_settings, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
